### src/met_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the escape-time evaluator.
// No dependencies; imported by met_ctrl, met_datapath and mandelbrot_escape_time.

package met_pkg;

   localparam int MAX_ITER_DEFAULT    = 512;
   localparam int COORD_WIDTH_DEFAULT = 12;

   localparam int Q_W         = 32;  // Q4.28 word
   localparam int FRAC_W      = 28;
   localparam int DIM_W       = 13;  // image width / height registers
   localparam int COUNT_OUT_W = 10;  // iteration_count field

   // register indexes on the csr channel; the two spares are ignored
   typedef enum logic [2:0] {
      CSR_X_MIN,
      CSR_X_MAX,
      CSR_Y_MIN,
      CSR_Y_MAX,
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_SPARE6,
      CSR_SPARE7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_ABS,
      ST_MAP_DIV,
      ST_MAP_ADD,
      ST_ITER_MUL,
      ST_ITER_UPD,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;      // capture pixel, clear z and count
      logic map_mul;   // p * (hi - lo)
      logic map_abs;   // split product into sign and magnitude
      logic div_step;  // one quotient bit
      logic map_add;   // lo +/- quotient, saturate
      logic axis;      // 0: real axis, 1: imaginary axis
      logic iter_mul;  // x*x, y*y, x*y
      logic iter_upd;  // escape test and z update
      logic out_load;  // load result register
   } cmd_type;

   typedef struct packed {
      logic escape;      // |z|^2 >= 4
      logic fixed;       // new z equals old z
      logic count_last;  // this iteration reaches the maximum
   } status_type;

endpackage

### src/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// Top level of the escape-time evaluator: register file, controller and datapath.
// Depends on met_pkg, met_ctrl, met_datapath.
//
// Usage
//  - req_*: one pixel per transfer. tdata = pixel_x (low), pixel_y, zero padding.
//  - rsp_*: one result per pixel. tdata = out_x (low), out_y, iteration_count.
//  - csr_*: register writes (index 0..5: x_min, x_max, y_min, y_max, width,
//    height). Ready whenever reset is low; write only while no pixel is in flight.
//  - One pixel at a time. Per axis the coordinate map is a multiply, a sign
//    split, a 44-step (at COORD_WIDTH = 12) shared restoring divider and a
//    saturating add; each iteration is a square state (three 32x32 products)
//    then an update state (escape test, saturating add, fixed-point compare).
//  - The next pixel can be accepted in the same cycle as rsp_tvalid rises.
//  - The result sits in its own register, so the next pixel is accepted while
//    a result waits; if rsp_tready stays low the finished next result waits
//    in the datapath until the register is freed, and req_tready stays low.
//  - Reset (synchronous, active high) empties the pipeline, drops any pending
//    result and restores the window to [-2.5, 1.0] x [-1.0, 1.0] at 800 x 457.

module mandelbrot_escape_time #(
   parameter int  MAX_ITERATIONS = met_pkg::MAX_ITER_DEFAULT,
   parameter int  COORD_WIDTH    = met_pkg::COORD_WIDTH_DEFAULT,
   localparam int REQ_W          = ((2 * COORD_WIDTH + 7) / 8) * 8,
   localparam int RSP_W          = ((2 * COORD_WIDTH + met_pkg::COUNT_OUT_W + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // pixel_x, pixel_y
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_W-1:0]          req_tdata,
   // out_x, out_y, iteration_count
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [met_pkg::Q_W-1:0]   csr_wdata
);
   import met_pkg::*;

   localparam logic signed [Q_W-1:0] X_MIN_RST = -32'sd671088640;  // -2.5
   localparam logic signed [Q_W-1:0] X_MAX_RST = 32'sd268435456;   //  1.0
   localparam logic signed [Q_W-1:0] Y_MIN_RST = -32'sd268435456;  // -1.0
   localparam logic signed [Q_W-1:0] Y_MAX_RST = 32'sd268435456;   //  1.0
   localparam logic [DIM_W-1:0]      WIDTH_RST  = 13'd800;
   localparam logic [DIM_W-1:0]      HEIGHT_RST = 13'd457;

   logic signed [Q_W-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [DIM_W-1:0]      width_ff, height_ff;

   cmd_type               cmd;
   status_type            status;
   logic [COORD_WIDTH-1:0] out_x, out_y;
   logic [COUNT_OUT_W-1:0] iteration_count;

   assign csr_ready = !reset;

   // window registers; the user must write them only between pixels, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff  <= X_MIN_RST;
         x_max_ff  <= X_MAX_RST;
         y_min_ff  <= Y_MIN_RST;
         y_max_ff  <= Y_MAX_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_MIN:  x_min_ff  <= signed'(csr_wdata);
            CSR_X_MAX:  x_max_ff  <= signed'(csr_wdata);
            CSR_Y_MIN:  y_min_ff  <= signed'(csr_wdata);
            CSR_Y_MAX:  y_max_ff  <= signed'(csr_wdata);
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default:    x_min_ff  <= x_min_ff;  // unmapped index ignored
         endcase
      end
   end

   met_ctrl #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   met_datapath #(
      .MAX_ITERATIONS (MAX_ITERATIONS),
      .COORD_WIDTH    (COORD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .pixel_x         (req_tdata[COORD_WIDTH-1:0]),
      .pixel_y         (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .x_min           (x_min_ff),
      .x_max           (x_max_ff),
      .y_min           (y_min_ff),
      .y_max           (y_max_ff),
      .width           (width_ff),
      .height          (height_ff),
      .out_x           (out_x),
      .out_y           (out_y),
      .iteration_count (iteration_count)
   );

   // fields packed from bit 0 upward, zero padded to whole bytes
   assign rsp_tdata = RSP_W'({iteration_count, out_y, out_x});

endmodule

### src/met_datapath.sv
`timescale 1ns / 1ps
// Datapath: coordinate mapping with a restoring divider, complex square loop, result register.
// Depends on met_pkg.

module met_datapath #(
   parameter int MAX_ITERATIONS = met_pkg::MAX_ITER_DEFAULT,
   parameter int COORD_WIDTH    = met_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  met_pkg::cmd_type                      cmd,
   output met_pkg::status_type                   status,
   input  logic [COORD_WIDTH-1:0]                pixel_x,
   input  logic [COORD_WIDTH-1:0]                pixel_y,
   input  logic signed [met_pkg::Q_W-1:0]        x_min,
   input  logic signed [met_pkg::Q_W-1:0]        x_max,
   input  logic signed [met_pkg::Q_W-1:0]        y_min,
   input  logic signed [met_pkg::Q_W-1:0]        y_max,
   input  logic [met_pkg::DIM_W-1:0]             width,
   input  logic [met_pkg::DIM_W-1:0]             height,
   output logic [COORD_WIDTH-1:0]                out_x,
   output logic [COORD_WIDTH-1:0]                out_y,
   output logic [met_pkg::COUNT_OUT_W-1:0]       iteration_count
);
   import met_pkg::*;

   localparam int CNT_W     = $clog2(MAX_ITERATIONS + 1);
   localparam int CNT_EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
   localparam int DQ_W      = COORD_WIDTH + Q_W;      // |p * (hi - lo)| fits here
   localparam int PROD_W    = COORD_WIDTH + Q_W + 2;
   localparam int REM_W     = DIM_W;
   localparam logic signed [63:0] Q_MAX64  = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] Q_MIN64  = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [63:0] ESC_BND  = 64'sh0000_0000_4000_0000;  // 4.0

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
      logic signed [Q_W-1:0] r;
      if (v > Q_MAX64) begin
         r = Q_MAX64[Q_W-1:0];
      end else if (v < Q_MIN64) begin
         r = Q_MIN64[Q_W-1:0];
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

   logic [COORD_WIDTH-1:0]     px_ff, py_ff;
   logic signed [Q_W-1:0]      cx_ff, cy_ff, x_ff, y_ff;
   logic signed [63:0]         xx_ff, yy_ff, xy_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       neg_ff;
   logic [DQ_W-1:0]            dq_ff;
   logic [REM_W-1:0]           rem_ff;
   logic [DIM_W-1:0]           divisor_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [COORD_WIDTH-1:0]     out_x_ff, out_y_ff;
   logic [COUNT_OUT_W-1:0]     out_cnt_ff;

   // mapping
   logic [COORD_WIDTH-1:0]     p_sel;
   logic signed [Q_W-1:0]      lo_sel, hi_sel;
   logic [DIM_W-1:0]           size_sel;
   logic signed [Q_W:0]        diff;
   logic signed [PROD_W-1:0]   prod_in, neg_prod;
   logic [DQ_W-1:0]            mag_in;
   logic [DIM_W-1:0]           divisor_in;
   logic [REM_W:0]             rem_shift, trial;
   logic                       q_bit;
   logic [REM_W-1:0]           rem_in;
   logic signed [63:0]         lo_w, dq_w, map_sum;
   logic signed [Q_W-1:0]      c_in;

   // iteration
   logic signed [63:0]         xx_in, yy_in, xy_in, sx, sy, pxy;
   logic signed [Q_W-1:0]      nx_in, ny_in;
   logic [CNT_W-1:0]           count_in;
   logic [CNT_EXT_W-1:0]       cnt_ext;

   assign p_sel    = cmd.axis ? py_ff : px_ff;
   assign lo_sel   = cmd.axis ? y_min : x_min;
   assign hi_sel   = cmd.axis ? y_max : x_max;
   assign size_sel = cmd.axis ? height : width;

   assign diff       = (Q_W + 1)'(hi_sel) - (Q_W + 1)'(lo_sel);
   assign prod_in    = PROD_W'(signed'({1'b0, p_sel})) * PROD_W'(diff);
   assign divisor_in = (size_sel == '0) ? DIM_W'(1) : size_sel;

   assign neg_prod = -prod_ff;
   assign mag_in   = prod_ff[PROD_W-1] ? neg_prod[DQ_W-1:0] : prod_ff[DQ_W-1:0];

   // restoring division, quotient shifts into dq_ff as the dividend shifts out
   assign rem_shift = {rem_ff, dq_ff[DQ_W-1]};
   assign trial     = rem_shift - {1'b0, divisor_ff};
   assign q_bit     = (rem_shift >= {1'b0, divisor_ff});
   assign rem_in    = q_bit ? trial[REM_W-1:0] : rem_shift[REM_W-1:0];

   // quotient truncated toward zero: apply the sign to the magnitude
   assign lo_w    = 64'(lo_sel);
   assign dq_w    = signed'(64'(dq_ff));
   assign map_sum = neg_ff ? (lo_w - dq_w) : (lo_w + dq_w);
   assign c_in    = sat_q(map_sum);

   assign xx_in = 64'(x_ff) * 64'(x_ff);
   assign yy_in = 64'(y_ff) * 64'(y_ff);
   assign xy_in = 64'(x_ff) * 64'(y_ff);

   // floor shifts; 2xy is one bit less shift
   assign sx  = xx_ff >>> FRAC_W;
   assign sy  = yy_ff >>> FRAC_W;
   assign pxy = xy_ff >>> (FRAC_W - 1);

   assign nx_in = sat_q(sx - sy + 64'(cx_ff));
   assign ny_in = sat_q(pxy + 64'(cy_ff));

   assign status.escape     = ((sx + sy) >= ESC_BND);
   assign status.fixed      = (nx_in == x_ff) && (ny_in == y_ff);
   assign status.count_last = (count_ff == CNT_W'(MAX_ITERATIONS - 1));

   assign count_in = status.fixed ? CNT_W'(MAX_ITERATIONS) : (count_ff + CNT_W'(1));
   assign cnt_ext  = CNT_EXT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff    <= pixel_x;
         py_ff    <= pixel_y;
         x_ff     <= '0;
         y_ff     <= '0;
         count_ff <= '0;
      end
      if (cmd.map_mul) begin
         prod_ff    <= prod_in;
         divisor_ff <= divisor_in;
      end
      if (cmd.map_abs) begin
         dq_ff  <= mag_in;
         neg_ff <= prod_ff[PROD_W-1];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff  <= {dq_ff[DQ_W-2:0], q_bit};
         rem_ff <= rem_in;
      end
      if (cmd.map_add) begin
         if (cmd.axis) begin
            cy_ff <= c_in;
         end else begin
            cx_ff <= c_in;
         end
      end
      if (cmd.iter_mul) begin
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         xy_ff <= xy_in;
      end
      if (cmd.iter_upd && !status.escape) begin
         count_ff <= count_in;
         if (!status.fixed) begin
            x_ff <= nx_in;
            y_ff <= ny_in;
         end
      end
      if (cmd.out_load) begin
         out_x_ff   <= px_ff;
         out_y_ff   <= py_ff;
         out_cnt_ff <= cnt_ext[COUNT_OUT_W-1:0];
      end
   end

   assign out_x           = out_x_ff;
   assign out_y           = out_y_ff;
   assign iteration_count = out_cnt_ff;

   // a fixed point forces the count straight to the maximum
   a_fixed_sat: assert property (@(posedge clock)
      (cmd.iter_upd && !status.escape && status.fixed) |=> count_ff == CNT_W'(MAX_ITERATIONS))
      else $error("fixed point did not saturate count");

   // z only moves on a non-escaping, non-fixed update
   a_z_hold: assert property (@(posedge clock)
      (cmd.iter_upd && status.escape) |=> (x_ff == $past(x_ff)) && (y_ff == $past(y_ff)))
      else $error("z changed on escape");

endmodule

### src/met_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences mapping, division and iteration, owns the handshakes.
// Depends on met_pkg.

module met_ctrl #(
   parameter int COORD_WIDTH = met_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  met_pkg::status_type status,
   output met_pkg::cmd_type    cmd
);
   import met_pkg::*;

   localparam int DIV_STEPS = COORD_WIDTH + Q_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   state_type         state_ff, state_in;
   logic              axis_ff, axis_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic              out_valid_ff, out_valid_in;
   logic              div_last;

   assign div_last = (div_cnt_ff == DCNT_W'(DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      div_cnt_in = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MAP_MUL;
               axis_in  = 1'b0;
            end
         end
         ST_MAP_MUL: state_in = ST_MAP_ABS;
         ST_MAP_ABS: begin
            state_in   = ST_MAP_DIV;
            div_cnt_in = '0;
         end
         ST_MAP_DIV: begin
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_last) begin
               state_in = ST_MAP_ADD;
            end
         end
         ST_MAP_ADD: begin
            if (axis_ff) begin
               state_in = ST_ITER_MUL;
            end else begin
               state_in = ST_MAP_MUL;
               axis_in  = 1'b1;
            end
         end
         ST_ITER_MUL: state_in = ST_ITER_UPD;
         ST_ITER_UPD: begin
            if (status.escape || status.fixed || status.count_last) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_ITER_MUL;
            end
         end
         ST_FLUSH: begin
            if (!out_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd      = '0;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE:     cmd.load     = req_tvalid;
         ST_MAP_MUL:  cmd.map_mul  = 1'b1;
         ST_MAP_ABS:  cmd.map_abs  = 1'b1;
         ST_MAP_DIV:  cmd.div_step = 1'b1;
         ST_MAP_ADD:  cmd.map_add  = 1'b1;
         ST_ITER_MUL: cmd.iter_mul = 1'b1;
         ST_ITER_UPD: cmd.iter_upd = 1'b1;
         ST_FLUSH:    cmd.out_load = !out_valid_ff || rsp_tready;
         default:     cmd.load     = 1'b0;
      endcase
   end

   assign out_valid_in = cmd.out_load | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // no transfer is taken while reset holds the controller
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = out_valid_ff;

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MAP_MUL) && !axis_ff)
      else $error("transfer accepted without starting real-axis mapping");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten before transfer");

   a_axes_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAP_ADD && axis_ff) |=> state_ff == ST_ITER_MUL)
      else $error("iteration did not follow imaginary-axis mapping");

   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAP_DIV) |-> div_cnt_ff <= DCNT_W'(DIV_STEPS - 1))
      else $error("division step count out of range");

endmodule
